[rtl/ddo_pkg.sv]
// Package for the differential-drive odometry integrator.
// Holds request and result types, register defaults, CORDIC constants.
// No dependencies.
`default_nettype none
package ddo_pkg;

  localparam int CordicStepsDef = 16;
  localparam int MulAW = 34;
  localparam int MulBW = 32;
  localparam int CordW = 36;
  localparam int AngW = 34;

  localparam logic [31:0] HeadPerRad = 32'd341782638;
  localparam logic [31:0] CordicInvGain = 32'd652032874;
  localparam logic [15:0] HwbReset = 16'd16384;
  localparam logic [23:0] InvReset = 24'd131072;

  localparam logic CfgHalfWheelBase = 1'b0;
  localparam logic CfgInvTrackWidth = 1'b1;

  typedef struct packed {
    logic signed [23:0] tan_speed;
    logic signed [23:0] rot_speed;
    logic [15:0] elapsed;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] pos_x_out;
    logic signed [31:0] pos_y_out;
    logic [31:0] heading_out;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [23:0] lin_vel;
    logic signed [31:0] ang_vel;
  } out_res_t;

  function automatic logic [29:0] atan_turn(input logic [4:0] idx);
    logic [29:0] r;
    case (idx)
      5'd0: r = 30'd536870912;
      5'd1: r = 30'd316933406;
      5'd2: r = 30'd167458907;
      5'd3: r = 30'd85004756;
      5'd4: r = 30'd42667331;
      5'd5: r = 30'd21354465;
      5'd6: r = 30'd10679838;
      5'd7: r = 30'd5340245;
      5'd8: r = 30'd2670163;
      5'd9: r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      5'd24: r = 30'd41;
      5'd25: r = 30'd20;
      5'd26: r = 30'd10;
      5'd27: r = 30'd5;
      5'd28: r = 30'd3;
      5'd29: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/ddo_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on ddo_pkg for operand widths.
`default_nettype none
module ddo_mul (
  input  wire                                  clk_i,
  input  wire signed [ddo_pkg::MulAW-1:0]      a_i,
  input  wire signed [ddo_pkg::MulBW-1:0]      b_i,
  output logic signed [ddo_pkg::MulAW+ddo_pkg::MulBW-1:0] p_o
);

  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end

endmodule
`default_nettype wire

[rtl/ddo_cordic.sv]
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on ddo_pkg for the arctangent table and widths.
`default_nettype none
module ddo_cordic #(
  parameter int CordicSteps = ddo_pkg::CordicStepsDef
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                start_i,
  input  wire signed [ddo_pkg::CordW-1:0]    x0_i,
  input  wire [31:0]                         turn_i,
  output logic                               done_o,
  output logic signed [ddo_pkg::CordW-9:0]   cos_o,
  output logic signed [ddo_pkg::CordW-9:0]   sin_o
);

  localparam int StepW = $clog2(CordicSteps);

  logic busy_q;
  logic [StepW-1:0] cnt_q;
  logic signed [ddo_pkg::CordW-1:0] x_q, y_q, xs, ys, xr, yr;
  logic signed [ddo_pkg::AngW-1:0] z_q, at;
  logic [31:0] u;

  assign xs = x_q >>> cnt_q;
  assign ys = y_q >>> cnt_q;
  assign at = ddo_pkg::AngW'({4'd0, ddo_pkg::atan_turn(5'(cnt_q))});
  assign u = turn_i - 32'h80000000;
  assign xr = x_q + ddo_pkg::CordW'(128);
  assign yr = y_q + ddo_pkg::CordW'(128);
  assign cos_o = xr[ddo_pkg::CordW-1:8];
  assign sin_o = yr[ddo_pkg::CordW-1:8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= '0;
      end else if (busy_q) begin
        if (cnt_q == StepW'(CordicSteps - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      y_q <= '0;
      if (((turn_i + 32'h40000000) & 32'h80000000) != 32'd0) begin
        x_q <= -x0_i;
        z_q <= ddo_pkg::AngW'($signed(u));
      end else begin
        x_q <= x0_i;
        z_q <= ddo_pkg::AngW'($signed(turn_i));
      end
    end else if (busy_q) begin
      if (z_q >= 0) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/diff_drive_odometry_integrator_core.sv]
// Differential-drive odometry integrator: sequencer, pose state, registers.
// One request at a time: the next request is taken only once the sequencer
// has presented the result and returned to idle. A stalled result holds the
// last step. Reset clears the pose and loads the register defaults. Depends
// on ddo_pkg, ddo_mul and ddo_cordic.
`default_nettype none
module diff_drive_odometry_integrator_core #(
  parameter int CordicSteps = ddo_pkg::CordicStepsDef
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  ddo_pkg::in_req_t    in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output ddo_pkg::out_res_t   out_data_o,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire [2:0]           paddr,
  input  wire [31:0]          pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MHW = 4'd1;
  localparam logic [3:0] S_LR = 4'd2;
  localparam logic [3:0] S_ML = 4'd3;
  localparam logic [3:0] S_MR = 4'd4;
  localparam logic [3:0] S_DD = 4'd5;
  localparam logic [3:0] S_MTH = 4'd6;
  localparam logic [3:0] S_MANG = 4'd7;
  localparam logic [3:0] S_MDH = 4'd8;
  localparam logic [3:0] S_MG1 = 4'd9;
  localparam logic [3:0] S_C1S = 4'd10;
  localparam logic [3:0] S_C1 = 4'd11;
  localparam logic [3:0] S_POS = 4'd12;
  localparam logic [3:0] S_C2S = 4'd13;
  localparam logic [3:0] S_C2 = 4'd14;
  localparam logic [3:0] S_FIN = 4'd15;

  localparam int PW = ddo_pkg::MulAW + ddo_pkg::MulBW;

  logic [3:0] state_q, state_d;
  logic [15:0] hwb_q;
  logic [23:0] inv_q;
  ddo_pkg::in_req_t in_q;
  logic signed [31:0] pose_x_q, pose_y_q, ang_q;
  logic [31:0] heading_q, dh_q, turn1;
  logic signed [24:0] left_q, right_q, dl_q, dr_q, d_q, hw;
  logic signed [25:0] dsum, ddiff, rl, lrsum;
  logic signed [33:0] dth_q, nx, ny;
  logic signed [ddo_pkg::MulAW-1:0] mul_a;
  logic signed [ddo_pkg::MulBW-1:0] mul_b;
  logic signed [PW-1:0] p_q, sh16, sh22;
  logic cor_start, cor_done;
  logic signed [ddo_pkg::CordW-9:0] cor_c, cor_s;
  logic signed [15:0] qz, qw;
  logic in_acc, out_free;

  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free = !out_valid_o || !out_stall_i;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {8'd0, inv_q} : {16'd0, hwb_q};

  assign sh16 = p_q >>> 16;
  assign sh22 = p_q >>> 22;
  assign hw = sh16[24:0];
  assign dsum = 26'(dl_q) + 26'(dr_q);
  assign ddiff = 26'(dr_q) - 26'(dl_q);
  assign rl = 26'(right_q) - 26'(left_q);
  assign lrsum = 26'(left_q) + 26'(right_q);
  assign turn1 = heading_q - dh_q;
  assign nx = 34'(pose_x_q) + 34'(cor_c);
  assign ny = 34'(pose_y_q) + 34'(cor_s);

  function automatic logic signed [15:0] clamp_q14(input logic signed [27:0] v);
    logic signed [15:0] r;
    if (v > 28'sd16384) begin
      r = 16'sd16384;
    end else if (v < -28'sd16384) begin
      r = -16'sd16384;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  assign qw = clamp_q14(cor_c);
  assign qz = clamp_q14(cor_s);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_MHW: begin
        mul_a = ddo_pkg::MulAW'(in_q.rot_speed);
        mul_b = {16'd0, hwb_q};
      end
      S_ML: begin
        mul_a = ddo_pkg::MulAW'(left_q);
        mul_b = {16'd0, in_q.elapsed};
      end
      S_MR: begin
        mul_a = ddo_pkg::MulAW'(right_q);
        mul_b = {16'd0, in_q.elapsed};
      end
      S_MTH: begin
        mul_a = ddo_pkg::MulAW'(ddiff);
        mul_b = {8'd0, inv_q};
      end
      S_MANG: begin
        mul_a = ddo_pkg::MulAW'(rl);
        mul_b = {8'd0, inv_q};
      end
      S_MDH: begin
        mul_a = dth_q;
        mul_b = ddo_pkg::HeadPerRad;
      end
      S_MG1: begin
        mul_a = ddo_pkg::MulAW'(d_q);
        mul_b = ddo_pkg::CordicInvGain;
      end
      S_POS: begin
        mul_a = ddo_pkg::MulAW'(16384);
        mul_b = ddo_pkg::CordicInvGain;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign cor_start = (state_q == S_C1S) || (state_q == S_C2S);

  ddo_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (p_q)
  );

  ddo_cordic #(
    .CordicSteps(CordicSteps)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .x0_i    (sh22[ddo_pkg::CordW-1:0]),
    .turn_i  ((state_q == S_C1S) ? {turn1[30:0], 1'b0} : heading_q),
    .done_o  (cor_done),
    .cos_o   (cor_c),
    .sin_o   (cor_s)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_MHW;
      S_MHW: state_d = S_LR;
      S_LR: state_d = S_ML;
      S_ML: state_d = S_MR;
      S_MR: state_d = S_DD;
      S_DD: state_d = S_MTH;
      S_MTH: state_d = S_MANG;
      S_MANG: state_d = S_MDH;
      S_MDH: state_d = S_MG1;
      S_MG1: state_d = S_C1S;
      S_C1S: state_d = S_C1;
      S_C1: if (cor_done) state_d = S_POS;
      S_POS: state_d = S_C2S;
      S_C2S: state_d = S_C2;
      S_C2: if (cor_done) state_d = S_FIN;
      S_FIN: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_o <= 1'b0;
      hwb_q <= ddo_pkg::HwbReset;
      inv_q <= ddo_pkg::InvReset;
      pose_x_q <= '0;
      pose_y_q <= '0;
      heading_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_FIN && out_free) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      if (psel && penable && pwrite) begin
        unique case (paddr[2])
          ddo_pkg::CfgHalfWheelBase: hwb_q <= pwdata[15:0];
          ddo_pkg::CfgInvTrackWidth: inv_q <= pwdata[23:0];
          default: ;
        endcase
      end
      if (state_q == S_POS) begin
        pose_x_q <= ddo_pkg::sat32(nx);
        pose_y_q <= ddo_pkg::sat32(ny);
        heading_q <= heading_q + dh_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) in_q <= in_data_i;
    if (state_q == S_LR) begin
      left_q <= 25'(in_q.tan_speed) - hw;
      right_q <= 25'(in_q.tan_speed) + hw;
    end
    if (state_q == S_MR) dl_q <= sh16[24:0];
    if (state_q == S_DD) dr_q <= sh16[24:0];
    if (state_q == S_MTH) d_q <= dsum[25:1];
    if (state_q == S_MANG) dth_q <= sh16[33:0];
    if (state_q == S_MDH) ang_q <= ddo_pkg::sat32(sh16[33:0]);
    if (state_q == S_MG1) dh_q <= p_q[47:16];
    if (state_q == S_FIN && out_free) begin
      out_data_o.pos_x_out <= pose_x_q;
      out_data_o.pos_y_out <= pose_y_q;
      out_data_o.heading_out <= heading_q;
      out_data_o.quat_z <= qz;
      out_data_o.quat_w <= qw;
      out_data_o.lin_vel <= lrsum[24:1];
      out_data_o.ang_vel <= ang_q;
    end
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_MHW)
    else $error("accepted request did not start the sequence");

  a_fin_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_free) |=> (out_valid_o && state_q == S_IDLE))
    else $error("finished request not presented");

  a_cordic_done_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_done |-> (state_q == S_C1 || state_q == S_C2))
    else $error("CORDIC finished outside a wait state");

endmodule
`default_nettype wire
